// ----- hdl/sbl_pkg.sv -----
// package: shared constants, register codes and types of the scaled beta log prior
package sbl_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int LFRAC = 26;
  localparam int ZW    = 31;
  localparam int TW    = 62;
  localparam int CW    = 64;

  localparam logic signed [30:0] LN2_Q30 = 31'sd744261118;

  localparam int MU_RST = 32768;
  localparam int SD_RST = 16384;
  localparam int LO_RST = 0;
  localparam int HI_RST = 65536;

  localparam logic [1:0] REG_MEAN = 2'd0;
  localparam logic [1:0] REG_STD  = 2'd1;
  localparam logic [1:0] REG_LOW  = 2'd2;
  localparam logic [1:0] REG_HIGH = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_CFG   = 2'd2;

  typedef enum logic [2:0] {
    CS_LOAD,
    CS_MUL,
    CS_DIV,
    CS_PREP,
    CS_SCL,
    CS_FIN,
    CS_RUN
  } coef_state_t;

  typedef struct packed {
    logic                 ready;
    logic                 bad;
    logic signed [CW-1:0] c1;
    logic signed [CW-1:0] c2;
  } sbl_coef_t;

  typedef struct packed {
    logic [ZW-1:0]    z;
    logic [LFRAC-1:0] frac;
  } sbl_lane_t;

endpackage

// ----- hdl/sbl_cell.sv -----
// one log2 cell: squares both mantissas and shifts one fraction bit into each lane
module sbl_cell import sbl_pkg::*; #(
  parameter int SIDE_W = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  sbl_lane_t         in_lane1,
  input  sbl_lane_t         in_lane2,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output sbl_lane_t         out_lane1,
  output sbl_lane_t         out_lane2,
  output logic [SIDE_W-1:0] out_side
);

  logic [2*ZW-1:0]   sq1, sq2;
  logic [ZW:0]       zz1, zz2;
  sbl_lane_t         lane1_nxt, lane2_nxt;
  logic              vld_r;
  sbl_lane_t         lane1_r, lane2_r;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    sq1 = in_lane1.z * in_lane1.z;
    sq2 = in_lane2.z * in_lane2.z;
    zz1 = sq1[2*ZW-1:ZW-1];
    zz2 = sq2[2*ZW-1:ZW-1];
    lane1_nxt.z    = zz1[ZW] ? zz1[ZW:1] : zz1[ZW-1:0];
    lane1_nxt.frac = {in_lane1.frac[LFRAC-2:0], zz1[ZW]};
    lane2_nxt.z    = zz2[ZW] ? zz2[ZW:1] : zz2[ZW-1:0];
    lane2_nxt.frac = {in_lane2.frac[LFRAC-2:0], zz2[ZW]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    lane1_r <= lane1_nxt;
    lane2_r <= lane2_nxt;
    side_r  <= in_side;
  end

  assign out_vld   = vld_r;
  assign out_lane1 = lane1_r;
  assign out_lane2 = lane2_r;
  assign out_side  = side_r;

endmodule

// ----- hdl/sbl_coef.sv -----
// coefficient sequencer: derives validity and the two log weights from the registers
module sbl_coef import sbl_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         restart,
  input  logic signed [DATA_WIDTH-1:0] mu,
  input  logic        [DATA_WIDTH-2:0] sigma,
  input  logic signed [DATA_WIDTH-1:0] lo,
  input  logic signed [DATA_WIDTH-1:0] hi,
  output sbl_coef_t                    coef
);

  localparam int W     = DATA_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int NUMW  = 2*W + 2 + F;
  localparam int VNW   = W + 1 + F;
  localparam int CNT_W = $clog2(NUMW);
  localparam int VC_W  = $clog2(VNW + 1);
  localparam int PWD   = 2*W + 2;
  localparam int S2W   = 2*W - 2;
  localparam int TMW   = TW + F + 1;

  coef_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VC_W-1:0]  vcnt_r;

  logic signed [W:0] d1, d2, rr;
  logic              pre_bad;

  logic [PWD-1:0]  mcand_r, p_r, p_nxt;
  logic [W:0]      mpl_r;
  logic [S2W-1:0]  smc_r, s2_r, s2_nxt;
  logic [W-2:0]    smp_r;
  logic            bad_r;

  logic [NUMW-1:0] num_r;
  logic [S2W-1:0]  rem_r, rem_nxt;
  logic [S2W:0]    trial, tdiff;
  logic            ge;
  logic [TW-1:0]   q_r;
  logic            qsat_r;

  logic [VNW-1:0]  vnum_r;
  logic [W:0]      vrem_r, vrem_nxt;
  logic [W+1:0]    vtrial, vdiff;
  logic            vge;
  logic [F:0]      vq_r;

  logic [TW-1:0]   tp1, tval;
  logic [TMW-1:0]  tmc_r, macc_r, nacc_r;
  logic [F:0]      vm_r, nm_r;
  logic signed [CW-1:0] c1_r, c2_r;

  always_comb begin
    d1 = {mu[W-1], mu} - {lo[W-1], lo};
    d2 = {hi[W-1], hi} - {mu[W-1], mu};
    rr = {hi[W-1], hi} - {lo[W-1], lo};
    pre_bad = (sigma == '0) || (lo >= hi) || (d1 <= 0) || (d2 <= 0);

    p_nxt  = p_r + (mpl_r[0] ? mcand_r : '0);
    s2_nxt = s2_r + (smp_r[0] ? smc_r : '0);

    trial   = {rem_r, num_r[NUMW-1]};
    tdiff   = trial - {1'b0, s2_r};
    ge      = trial >= {1'b0, s2_r};
    rem_nxt = ge ? tdiff[S2W-1:0] : trial[S2W-1:0];

    vtrial   = {vrem_r, vnum_r[VNW-1]};
    vdiff    = vtrial - {1'b0, rr};
    vge      = vtrial >= {1'b0, rr};
    vrem_nxt = vge ? vdiff[W:0] : vtrial[W:0];

    tp1  = qsat_r ? {TW{1'b1}} : q_r;
    tval = tp1 - (TW'(1) << F);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_LOAD: state_nxt = CS_MUL;
      CS_MUL:  if (cnt_r == '0) state_nxt = CS_DIV;
      CS_DIV:  if (cnt_r == '0) state_nxt = CS_PREP;
      CS_PREP: state_nxt = CS_SCL;
      CS_SCL:  if (cnt_r == '0) state_nxt = CS_FIN;
      CS_FIN:  state_nxt = CS_RUN;
      CS_RUN:  state_nxt = CS_RUN;
      default: state_nxt = CS_LOAD;
    endcase
    if (restart) state_nxt = CS_LOAD;
  end

  // counter update and outputs
  always_comb begin
    cnt_nxt = cnt_r;
    unique case (state_r)
      CS_LOAD: cnt_nxt = CNT_W'(W);
      CS_MUL:  cnt_nxt = (cnt_r == '0) ? CNT_W'(NUMW - 1) : cnt_r - 1'b1;
      CS_DIV:  cnt_nxt = cnt_r - 1'b1;
      CS_PREP: cnt_nxt = CNT_W'(F);
      CS_SCL:  cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
    coef.ready = (state_r == CS_RUN);
    coef.bad   = bad_r;
    coef.c1    = c1_r;
    coef.c2    = c2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_LOAD;
      cnt_r   <= '0;
      vcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == CS_LOAD) begin
        vcnt_r <= VC_W'(VNW);
      end else if (vcnt_r != '0) begin
        vcnt_r <= vcnt_r - 1'b1;
      end
    end
  end

  // quotient for v runs beside the multiply and divide phases
  always_ff @(posedge clk) begin
    if (state_r == CS_LOAD) begin
      vnum_r <= {d1, {F{1'b0}}};
      vrem_r <= '0;
      vq_r   <= '0;
    end else if (vcnt_r != '0) begin
      vnum_r <= {vnum_r[VNW-2:0], 1'b0};
      vrem_r <= vrem_nxt;
      vq_r   <= {vq_r[F-1:0], vge};
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      CS_LOAD: begin
        mcand_r <= PWD'(d1);
        mpl_r   <= d2;
        p_r     <= '0;
        smc_r   <= S2W'(sigma);
        smp_r   <= sigma;
        s2_r    <= '0;
        rem_r   <= '0;
        q_r     <= '0;
        qsat_r  <= 1'b0;
      end
      CS_MUL: begin
        p_r     <= p_nxt;
        s2_r    <= s2_nxt;
        mcand_r <= {mcand_r[PWD-2:0], 1'b0};
        mpl_r   <= {1'b0, mpl_r[W:1]};
        smc_r   <= {smc_r[S2W-2:0], 1'b0};
        smp_r   <= smp_r >> 1;
        if (cnt_r == '0) begin
          num_r <= {p_nxt, {F{1'b0}}};
          bad_r <= pre_bad || (p_nxt <= PWD'(s2_nxt));
        end
      end
      CS_DIV: begin
        num_r  <= {num_r[NUMW-2:0], 1'b0};
        rem_r  <= rem_nxt;
        q_r    <= {q_r[TW-2:0], ge};
        qsat_r <= qsat_r | q_r[TW-1];
      end
      CS_PREP: begin
        tmc_r  <= TMW'(tval);
        vm_r   <= vq_r;
        nm_r   <= ((F+1)'(1) << F) - vq_r;
        macc_r <= '0;
        nacc_r <= '0;
      end
      CS_SCL: begin
        macc_r <= macc_r + (vm_r[0] ? tmc_r : '0);
        nacc_r <= nacc_r + (nm_r[0] ? tmc_r : '0);
        tmc_r  <= {tmc_r[TMW-2:0], 1'b0};
        vm_r   <= vm_r >> 1;
        nm_r   <= nm_r >> 1;
      end
      CS_FIN: begin
        c1_r <= (CW'(1) << F) - CW'(macc_r[TMW-1:F]);
        c2_r <= (CW'(1) << F) - CW'(nacc_r[TMW-1:F]);
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/scaled_beta_log_prior.sv -----
// top level: scaled beta prior negative log density, one sample per cycle while busy is low
//
// Writing a register on cfg_we/cfg_index/cfg_data restarts the coefficient
// sequencer, which holds busy high while its shift-add multipliers and
// bit-serial dividers derive the weights; after reset it runs the same pass
// with the default registers. While busy is low a sample is taken at every
// edge with start high, one beat per cycle, back to back. Each beat goes
// through the range check, a leading-one stage, a barrel shift, a row of 26
// squaring cells (one log2 fraction bit each), the ln2 scaling and the weight
// multiplies; the result shows on out_log_prior/out_status with out_valid
// high for one cycle.
// Results leave in order at one per cycle; the receiver cannot stall them.
// Status 2 flags an invalid configuration, status 1 a sample outside (a,b);
// both give a zero result. Reset clears the pipeline and loads the default
// registers.
module scaled_beta_log_prior import sbl_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_sample_value,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_log_prior,
  output logic        [1:0]            out_status,
  input  logic                         cfg_we,
  input  logic        [1:0]            cfg_index,
  input  logic        [DATA_WIDTH-1:0] cfg_data
);

  localparam int W      = DATA_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int KW     = $clog2(W + 1);
  localparam int L2W    = KW + 1 + LFRAC;
  localparam int PRW    = L2W + 31;
  localparam int SHR    = 56 - F;
  localparam int LNW    = F + 8;
  localparam int PW     = CW + LNW;
  localparam int SUMW   = PW + 1;
  localparam int NCELL  = LFRAC;
  localparam int SIDE_W = 2*KW + 2;
  localparam int NPOST  = 5;

  localparam logic signed [PRW-1:0]  RND  = {{(PRW-SHR){1'b0}}, {SHR{1'b1}}};
  localparam logic signed [SUMW-1:0] OMAX = {{(SUMW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SUMW-1:0] OMIN = {{(SUMW-W+1){1'b1}}, {(W-1){1'b0}}};

  logic signed [W-1:0] mu_r, lo_r, hi_r;
  logic        [W-2:0] sd_r;
  sbl_coef_t           coef;
  logic                accept;

  logic                v0_r, v1_r, v2_r;
  logic signed [W:0]   xe, y1, y2;
  logic [W:0]          y1_r, y2_r, y1b_r, y2b_r;
  logic [1:0]          st0, st0_r, st1_r, st2_r;
  logic [KW-1:0]       k1, k2, k1_r, k2_r, k1c_r, k2c_r, sa1, sa2;
  logic [W+ZW-1:0]     sh1, sh2;
  sbl_lane_t           l1_r, l2_r;

  sbl_lane_t           ch1 [NCELL+1];
  sbl_lane_t           ch2 [NCELL+1];
  logic                chv [NCELL+1];
  logic [SIDE_W-1:0]   chs [NCELL+1];

  logic [KW-1:0]       ke1, ke2;
  logic signed [KW:0]  kmf1, kmf2;
  logic signed [L2W-1:0] lg1, lg2;
  logic signed [PRW-1:0] pr1, pr2, pr1_r, pr2_r, rn1, rn2, rs1, rs2;
  logic signed [LNW-1:0] ln1_r, ln2_r;
  logic signed [33+LNW-1:0] pl1_r, pl2_r;
  logic signed [32+LNW-1:0] ph1_r, ph2_r;
  logic signed [PW-1:0]   prod1_r, prod2_r;
  logic signed [SUMW-1:0] sum, shs_r;

  logic                pv_r  [NPOST];
  logic [1:0]          pst_r [NPOST];

  logic                ov_r;
  logic signed [W-1:0] olp_r;
  logic [1:0]          ost_r;
  logic signed [W-1:0] sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r <= W'(MU_RST);
      sd_r <= (W-1)'(SD_RST);
      lo_r <= W'(LO_RST);
      hi_r <= W'(HI_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MEAN: mu_r <= cfg_data;
        REG_STD:  sd_r <= cfg_data[W-2:0];
        REG_LOW:  lo_r <= cfg_data;
        REG_HIGH: hi_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sbl_coef #(
    .FRAC_BITS (F),
    .DATA_WIDTH(W)
  ) u_coef (
    .clk    (clk),
    .rst_n  (rst_n),
    .restart(cfg_we),
    .mu     (mu_r),
    .sigma  (sd_r),
    .lo     (lo_r),
    .hi     (hi_r),
    .coef   (coef)
  );

  assign busy   = !coef.ready;
  assign accept = start && !busy;

  // range check and distances to both ends
  always_comb begin
    xe = {in_sample_value[W-1], in_sample_value};
    y1 = xe - {lo_r[W-1], lo_r};
    y2 = {hi_r[W-1], hi_r} - xe;
    if (coef.bad) begin
      st0 = ST_CFG;
    end else if (in_sample_value <= lo_r || in_sample_value >= hi_r) begin
      st0 = ST_RANGE;
    end else begin
      st0 = ST_OK;
    end
  end

  // leading one position
  always_comb begin
    k1 = '0;
    k2 = '0;
    for (int i = 0; i <= W; i++) begin
      if (y1_r[i]) k1 = KW'(i);
      if (y2_r[i]) k2 = KW'(i);
    end
  end

  // mantissa into [2^30, 2^31)
  always_comb begin
    sa1 = KW'(W) - k1_r;
    sa2 = KW'(W) - k2_r;
    sh1 = {y1b_r, {(ZW-1){1'b0}}} << sa1;
    sh2 = {y2b_r, {(ZW-1){1'b0}}} << sa2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= accept;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    y1_r   <= y1;
    y2_r   <= y2;
    st0_r  <= st0;
    y1b_r  <= y1_r;
    y2b_r  <= y2_r;
    k1_r   <= k1;
    k2_r   <= k2;
    st1_r  <= st0_r;
    l1_r.z    <= sh1[W+ZW-1 -: ZW];
    l1_r.frac <= '0;
    l2_r.z    <= sh2[W+ZW-1 -: ZW];
    l2_r.frac <= '0;
    k1c_r  <= k1_r;
    k2c_r  <= k2_r;
    st2_r  <= st1_r;
  end

  assign ch1[0] = l1_r;
  assign ch2[0] = l2_r;
  assign chv[0] = v2_r;
  assign chs[0] = {st2_r, k1c_r, k2c_r};

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    sbl_cell #(
      .SIDE_W(SIDE_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (chv[g]),
      .in_lane1 (ch1[g]),
      .in_lane2 (ch2[g]),
      .in_side  (chs[g]),
      .out_vld  (chv[g+1]),
      .out_lane1(ch1[g+1]),
      .out_lane2(ch2[g+1]),
      .out_side (chs[g+1])
    );
  end

  // log2 to ln, truncated toward zero
  always_comb begin
    ke1  = chs[NCELL][2*KW-1:KW];
    ke2  = chs[NCELL][KW-1:0];
    kmf1 = $signed({1'b0, ke1}) - $signed((KW+1)'(F));
    kmf2 = $signed({1'b0, ke2}) - $signed((KW+1)'(F));
    lg1  = $signed({kmf1, ch1[NCELL].frac});
    lg2  = $signed({kmf2, ch2[NCELL].frac});
    pr1  = lg1 * LN2_Q30;
    pr2  = lg2 * LN2_Q30;
    rn1  = pr1_r + (pr1_r[PRW-1] ? RND : '0);
    rn2  = pr2_r + (pr2_r[PRW-1] ? RND : '0);
    rs1  = rn1 >>> SHR;
    rs2  = rn2 >>> SHR;
    sum  = SUMW'(prod1_r) + SUMW'(prod2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NPOST; i++) pv_r[i] <= 1'b0;
    end else begin
      pv_r[0] <= chv[NCELL];
      for (int i = 1; i < NPOST; i++) pv_r[i] <= pv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    pst_r[0] <= chs[NCELL][SIDE_W-1 -: 2];
    for (int i = 1; i < NPOST; i++) pst_r[i] <= pst_r[i-1];
    pr1_r   <= pr1;
    pr2_r   <= pr2;
    ln1_r   <= rs1[LNW-1:0];
    ln2_r   <= rs2[LNW-1:0];
    pl1_r   <= $signed({1'b0, coef.c1[31:0]}) * ln1_r;
    ph1_r   <= $signed(coef.c1[CW-1:32]) * ln1_r;
    pl2_r   <= $signed({1'b0, coef.c2[31:0]}) * ln2_r;
    ph2_r   <= $signed(coef.c2[CW-1:32]) * ln2_r;
    prod1_r <= (PW'(ph1_r) <<< 32) + PW'(pl1_r);
    prod2_r <= (PW'(ph2_r) <<< 32) + PW'(pl2_r);
    shs_r   <= sum >>> F;
  end

  always_comb begin
    if (shs_r > OMAX) begin
      sat = OMAX[W-1:0];
    end else if (shs_r < OMIN) begin
      sat = OMIN[W-1:0];
    end else begin
      sat = shs_r[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= pv_r[NPOST-1];
    end
  end

  always_ff @(posedge clk) begin
    ost_r <= pst_r[NPOST-1];
    olp_r <= (pst_r[NPOST-1] == ST_OK) ? sat : '0;
  end

  assign out_valid     = ov_r;
  assign out_log_prior = olp_r;
  assign out_status    = ost_r;

  a_cfg_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("register write did not hold off samples");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_log_prior == '0)
    else $error("flagged beat carries a nonzero result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_RANGE ||
                   out_status == ST_CFG))
    else $error("unknown status code on result beat");

endmodule

// ----- dv/scaled_beta_log_prior_test.sv -----
// testbench: random and directed samples against a scaled beta log prior predictor
`timescale 1ns / 100ps

module scaled_beta_log_prior_test;
  import sbl_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam longint ONE = 64'sd1 << FB;
  localparam int LATENCY = 34;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic signed [DW-1:0] log_prior;
    logic [1:0]           status;
  } prior_beat_t;

  class prior_scoreboard;
    logic signed [DW-1:0] mu, lo, hi;
    logic [DW-2:0]        sd;
    prior_beat_t          pending[$];
    int                   errors;

    function new();
      mu = DW'(MU_RST); sd = (DW-1)'(SD_RST); lo = DW'(LO_RST); hi = DW'(HI_RST);
      errors = 0;
    endfunction

    // natural log of y / 2^FB in Q(FB), y > 0
    function longint ln_fixed(longint unsigned y);
      int k;
      longint unsigned z, frac;
      longint l2, prod;
      k = 63;
      frac = 0;
      while (k > 0 && !y[k]) k--;
      z = (k >= 30) ? (y >> (k - 30)) : (y << (30 - k));
      for (int i = 0; i < 26; i++) begin
        z = (z * z) >> 30;
        frac = frac << 1;
        if (z >= (64'd1 << 31)) begin
          frac = frac | 1;
          z = z >> 1;
        end
      end
      l2 = longint'(k - FB) * (64'sd1 << 26) + longint'(frac);
      prod = l2 * 64'sd744261118;
      if (prod < 0) return -longint'(longint'(-prod) >>> (56 - FB));
      return prod >>> (56 - FB);
    endfunction

    function prior_beat_t predict(logic signed [DW-1:0] xs);
      prior_beat_t r;
      longint a, b, m0, x, d1, d2, span, t, v, m, n, c1, c2;
      logic [127:0] p, s2, tp1, tmp;
      logic signed [127:0] w1, w2, g1, g2, acc;
      a = lo; b = hi; m0 = mu; x = xs;
      d1 = m0 - a; d2 = b - m0; span = b - a;
      r.log_prior = 0;
      if (sd == 0 || a >= b || d1 <= 0 || d2 <= 0) begin
        r.status = ST_CFG;
        return r;
      end
      p = 128'(d1) * 128'(d2);
      s2 = 128'(sd) * 128'(sd);
      if (p <= s2) begin
        r.status = ST_CFG;
        return r;
      end
      if (x <= a || x >= b) begin
        r.status = ST_RANGE;
        return r;
      end
      tp1 = (p << FB) / s2;
      if (tp1 > ((128'd1 << 62) - 1)) tp1 = (128'd1 << 62) - 1;
      t = longint'(tp1[63:0]) - ONE;
      v = (d1 << FB) / span;
      tmp = 128'(t) * 128'(v);
      m = longint'(tmp >> FB);
      tmp = 128'(t) * 128'(ONE - v);
      n = longint'(tmp >> FB);
      c1 = ONE - m;
      c2 = ONE - n;
      w1 = c1; w2 = c2;
      g1 = ln_fixed(longint'(x - a));
      g2 = ln_fixed(longint'(b - x));
      acc = (w1 * g1 + w2 * g2) >>> FB;
      if (acc > $signed(128'd2147483647)) r.log_prior = 32'h7fffffff;
      else if (acc < -$signed(128'd2147483648)) r.log_prior = 32'h80000000;
      else r.log_prior = acc[DW-1:0];
      r.status = ST_OK;
      return r;
    endfunction

    function void note_sample(logic signed [DW-1:0] xs);
      pending.push_back(predict(xs));
    endfunction

    function void check_result(logic signed [DW-1:0] lp, logic [1:0] st);
      prior_beat_t e;
      if (pending.size() == 0) begin
        $error("unexpected beat: log_prior %0d status %0d", lp, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (lp !== e.log_prior) begin
        $error("log_prior: expected %0d, got %0d", e.log_prior, lp);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [DW-1:0] in_sample_value = 0;
  logic out_valid;
  logic signed [DW-1:0] out_log_prior;
  logic [1:0] out_status;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_MEAN;
  logic [DW-1:0] cfg_data = 0;

  prior_scoreboard sb = new();
  int cycles = 0;

  scaled_beta_log_prior uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_value(in_sample_value), .out_valid(out_valid),
    .out_log_prior(out_log_prior), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("scaled_beta_log_prior_test: done, errors");
      $finish;
    end
    if (rst_n) begin
      if (start && !busy) sb.note_sample(in_sample_value);
      if (out_valid) sb.check_result(out_log_prior, out_status);
    end
  end

  int burst_left = 0;

  task automatic send_sample(logic signed [DW-1:0] xs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
      if (gap > 0) begin
        start <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : int'($urandom_range(1, 16));
    end
    burst_left--;
    start <= 1;
    in_sample_value <= xs;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_regs(logic [DW-1:0] m, logic [DW-2:0] s, logic [DW-1:0] l,
                          logic [DW-1:0] h);
    logic [DW-1:0] vals[4];
    vals = '{m, {1'b0, s}, l, h};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    sb.mu = m; sb.sd = s; sb.lo = l; sb.hi = h;
    repeat (2) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] pick_sample();
    longint a, b, x;
    a = sb.lo; b = sb.hi;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return DW'((a > b) ? a : a + $urandom_range(0, 1));
      2: return DW'(b - $urandom_range(0, 1));
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: begin
        if (b - a < 2) return DW'(a);
        x = a + 1 + longint'({$urandom(), $urandom()} % longint'(b - a - 1));
        return DW'(x);
      end
    endcase
  endfunction

  task automatic random_regs();
    longint a, b, span, d1, d2, lim;
    logic [DW-2:0] s;
    a = $signed($urandom());
    span = $urandom_range(0, 2) == 0 ? $urandom_range(2, 4096) : $urandom_range(2, 32'h7fffffff);
    b = a + span;
    if (b > 64'sd2147483647) begin
      b = 64'sd2147483647;
      a = b - span;
    end
    d1 = 1 + longint'($urandom()) % (b - a - 1);
    d2 = span - d1;
    lim = 1;
    while ((lim + 1) * (lim + 1) < d1 * d2 && lim < 64'h7fffffff) lim = lim * 2;
    s = ($urandom_range(0, 7) == 0) ? 31'($urandom()) : 31'($urandom_range(1, 32'(lim)));
    if (s == 0) s = 1;
    set_regs(32'(a + d1), s, 32'(a), 32'(b));
  endtask

  initial begin
    logic signed [DW-1:0] edge_vals[] = '{0, 1, 2, 32768, 65534, 65535, 65536, 65537,
      32'h7fffffff, 32'h80000000, -1, 16384, 49152};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // default prior, then a few extreme settings
    foreach (edge_vals[i]) send_sample(edge_vals[i]);
    set_regs(32'h0, 31'h7fffffff, 32'h80000000, 32'h7fffffff);
    foreach (edge_vals[i]) send_sample(edge_vals[i]);
    set_regs(32'h0, 31'h1, 32'h80000000, 32'h7fffffff);
    foreach (edge_vals[i]) send_sample(edge_vals[i]);
    repeat (20) send_sample(pick_sample());
    set_regs(32'h1, 31'h1, 32'h0, 32'h2);
    for (int i = -1; i < 4; i++) send_sample(i);
    set_regs(32'h8000, 31'h0, 32'h0, 32'h10000);
    repeat (4) send_sample(pick_sample());
    set_regs(32'h8000, 31'h4000, 32'h10000, 32'h10000);
    repeat (4) send_sample(pick_sample());
    set_regs(32'h20000, 31'h4000, 32'h0, 32'h10000);
    repeat (4) send_sample(pick_sample());
    set_regs(32'h8000, 31'h8000, 32'h0, 32'h10000);
    repeat (4) send_sample(pick_sample());
    set_regs(32'h7ffffffe, 31'h1, 32'h7ffffffd, 32'h7fffffff);
    repeat (6) send_sample(pick_sample());

    for (int ph = 0; ph < 14; ph++) begin
      random_regs();
      repeat (130) send_sample(pick_sample());
    end
    set_regs(DW'(MU_RST), (DW-1)'(SD_RST), DW'(LO_RST), DW'(HI_RST));
    repeat (150) send_sample(pick_sample());

    drain();
    if (sb.errors == 0) begin
      $display("scaled_beta_log_prior_test: done, clean");
    end else begin
      $display("scaled_beta_log_prior_test: done, errors");
    end
    $finish;
  end

endmodule
